FILE: src/stbs_pkg.sv
// Shared constants, word types and state encodings for the sorted table search block.
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SEARCH,
    OP_EMPTY
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEARCH
  } back_state_t;

  typedef struct packed {
    logic                          action;
    logic [IDX_W-1:0]              index;
    logic signed [VALUE_WIDTH-1:0] value;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } out_t;

  typedef struct packed {
    op_t                           op;
    logic [IDX_W-1:0]              index;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [CNT_W-1:0]              span;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } qhead_t;

endpackage

FILE: src/stbs_front.sv
// Front end: takes input words, classifies them and holds them in a short queue.
module stbs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  stbs_pkg::in_t                 in_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [stbs_pkg::CNT_W-1:0]    cfg_data,
  input  logic                          pop,
  output stbs_pkg::qhead_t              qhead
);
  import stbs_pkg::*;

  logic [CNT_W-1:0]  count_r;
  work_t             q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              accept;
  logic              do_pop;
  work_t             work_in;
  logic [CNT_W-1:0]  span;

  assign cfg_ready = 1'b1;
  assign busy      = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign accept    = start && !busy;
  assign do_pop    = pop && (fill_r != '0);

  // A count beyond the table is clipped, so the back end never probes past it.
  assign span = (count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_r;

  always_comb begin
    work_in.index = in_data.index;
    work_in.value = in_data.value;
    work_in.span  = span;
    if (in_data.action == ACT_LOAD) begin
      work_in.op = OP_LOAD;
    end else if (span == '0) begin
      work_in.op = OP_EMPTY;
    end else begin
      work_in.op = OP_SEARCH;
    end
  end

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    case ({accept, do_pop})
      2'b10:   fill_nxt = fill_r + (QPTR_W+1)'(1);
      2'b01:   fill_nxt = fill_r - (QPTR_W+1)'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem_r[wr_ptr_r] <= work_in;
    end
  end

  assign qhead.valid = (fill_r != '0);
  assign qhead.work  = q_mem_r[rd_ptr_r];

endmodule

FILE: src/stbs_back.sv
// Back end: table memory, load writes and the halving search with one probe per cycle.
module stbs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  stbs_pkg::qhead_t qhead,
  output logic             pop,
  output logic             out_valid,
  output stbs_pkg::out_t   out_data
);
  import stbs_pkg::*;

  logic signed [VALUE_WIDTH-1:0] mem_r [TABLE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rdata_r;
  logic signed [VALUE_WIDTH-1:0] key_r, key_nxt;
  back_state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]              lo_r, lo_nxt;
  logic [CNT_W-1:0]              hi_r, hi_nxt;
  logic [IDX_W-1:0]              mid_r, mid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_t                          out_data_r, out_data_nxt;
  logic                          wr_en;
  logic [IDX_W-1:0]              rd_addr;
  logic                          hit, less, more;
  logic [CNT_W-1:0]              lo_step, hi_step;
  logic [CNT_W-1:0]              sum_step, sum_first;

  // Probe outcome for the entry read in the previous cycle.
  assign hit       = (rdata_r == key_r);
  assign less      = (rdata_r < key_r);
  assign lo_step   = less ? {1'b0, mid_r} + CNT_W'(1) : lo_r;
  assign hi_step   = less ? hi_r : {1'b0, mid_r};
  assign more      = (lo_step < hi_step);
  assign sum_step  = lo_step + hi_step - CNT_W'(1);
  assign sum_first = qhead.work.span - CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (qhead.valid && qhead.work.op == OP_SEARCH) begin
          state_nxt = BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        if (hit || !more) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    wr_en         = 1'b0;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      BK_IDLE: begin
        pop = qhead.valid;
        if (qhead.valid) begin
          case (qhead.work.op)
            OP_LOAD: begin
              wr_en = 1'b1;
            end
            OP_SEARCH: begin
              lo_nxt  = '0;
              hi_nxt  = qhead.work.span;
              key_nxt = qhead.work.value;
              mid_nxt = sum_first[CNT_W-1:1];
            end
            OP_EMPTY: begin
              out_valid_nxt         = 1'b1;
              out_data_nxt.found    = 1'b0;
              out_data_nxt.position = '0;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      BK_SEARCH: begin
        if (hit) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.found    = 1'b1;
          out_data_nxt.position = mid_r;
        end else if (!more) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.found    = 1'b0;
          out_data_nxt.position = '0;
        end else begin
          lo_nxt  = lo_step;
          hi_nxt  = hi_step;
          mid_nxt = sum_step[CNT_W-1:1];
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // The next probe address is issued in the same cycle the outcome is known.
  assign rd_addr = mid_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[qhead.work.index] <= qhead.work.value;
    end
    rdata_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/sorted_table_binary_search.sv
// Top level of the sorted table search: front end, word queue and search back end.
//
//  Channel  Handshake              Payload                       Direction
//  in       start, busy            in_data  (action,index,value) into block
//  out      out_valid (strobe)     out_data (found,position)     out of block
//  cfg      cfg_valid, cfg_ready   cfg_data (entry_count)        into block
//
// A load word is written to the table memory when the back end takes it; a search is set up
// when taken and then makes one memory probe per halving step, the steps running one after
// another since the table memory has a single read port.
// Reset is synchronous and active low; it empties the queue and sets entry_count to 0.
// The front end keeps accepting words into a two-word queue while a search runs;
// busy rises only when that queue is full. Results are never held back.
module sorted_table_binary_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  stbs_pkg::in_t              in_data,
  output logic                       out_valid,
  output stbs_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [stbs_pkg::CNT_W-1:0] cfg_data
);
  import stbs_pkg::*;

  qhead_t qhead;
  logic   q_pop;

  stbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pop       (q_pop),
    .qhead     (qhead)
  );

  stbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qhead     (qhead),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.position == '0)
    else $error("not-found result carries a non-zero position");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> qhead.valid)
    else $error("accepted word did not reach the queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> qhead.valid)
    else $error("back end popped an empty queue");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("reset left a result strobe or a full queue");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the sorted table binary search block.
module testbench;
  import stbs_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;
  // The full-table test already sends one word per table entry, so the random
  // phases only top the total up to roughly 1250 words.
  localparam int RANDOM_ITEMS  = 200;
  localparam logic signed [VALUE_WIDTH-1:0] MIN_WORD = 32'sh8000_0000;
  localparam logic signed [VALUE_WIDTH-1:0] MAX_WORD = 32'sh7fff_ffff;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_t              in_data = '0;
  logic             out_valid;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  logic signed [VALUE_WIDTH-1:0] shadow_table [TABLE_DEPTH];
  logic [CNT_W-1:0]              entry_count_copy = '0;
  out_t                          expected_lookups [$];
  int                            idle_pct = 0;
  int                            cycle_count = 0;
  bit                            failed = 1'b0;

  sorted_table_binary_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_table_binary_search verification failed");
      $finish;
    end
  end

  // Halving search over the shadow copy, using the count as last written.
  function automatic out_t predict_search(input logic signed [VALUE_WIDTH-1:0] key);
    out_t r;
    int   lo;
    int   hi_ex;
    int   mid;
    r = '0;
    lo = 0;
    hi_ex = (entry_count_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_copy);
    while (lo < hi_ex) begin
      mid = (lo + hi_ex - 1) / 2;
      if (shadow_table[mid[IDX_W-1:0]] == key) begin
        r.found = 1'b1;
        r.position = mid[IDX_W-1:0];
        return r;
      end
      if (shadow_table[mid[IDX_W-1:0]] < key) lo = mid + 1;
      else hi_ex = mid;
    end
    return r;
  endfunction

  always @(posedge clk) begin : check_result
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_lookups.size() == 0) begin
        $error("result word with no search outstanding: found %0d position %0d",
               out_data.found, out_data.position);
        failed = 1'b1;
      end else begin
        want = expected_lookups.pop_front();
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_data.found);
          failed = 1'b1;
        end
        if (out_data.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_data.position);
          failed = 1'b1;
        end
      end
    end
  end

  // Every task below starts and ends just after a falling edge.
  task automatic send_word(input logic act, input logic [IDX_W-1:0] idx,
                           input logic signed [VALUE_WIDTH-1:0] val);
    in_t w;
    w.action = act;
    w.index  = idx;
    w.value  = val;
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start   = 1'b1;
    in_data = w;
    do @(posedge clk); while (busy);
    if (act == ACT_LOAD) shadow_table[idx] = val;
    else expected_lookups.push_back(predict_search(val));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic search_key(input logic signed [VALUE_WIDTH-1:0] key);
    send_word(ACT_SEARCH, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), key);
  endtask

  // Loads give no result, so the back end is given time to finish any load
  // still in the queue before the count changes.
  task automatic write_entry_count(input logic [CNT_W-1:0] n);
    while (expected_lookups.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = n;
    do @(posedge clk); while (!cfg_ready);
    entry_count_copy = n;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Writes entries 0..n-1 in ascending order, with duplicates now and then.
  task automatic fill_ascending(input int n);
    longint acc;
    acc = ($urandom_range(0, 3) == 0) ? longint'(MIN_WORD) : longint'($signed($urandom));
    for (int i = 0; i < n; i++) begin
      if (acc > longint'(MAX_WORD)) acc = longint'(MAX_WORD);
      send_word(ACT_LOAD, i[IDX_W-1:0], acc[VALUE_WIDTH-1:0]);
      if ($urandom_range(0, 4) == 0) acc += $urandom_range(0, 1 << 24);
      else acc += $urandom_range(0, 4);
    end
  endtask

  task automatic test_empty_table();
    search_key(0);
    search_key(MIN_WORD);
    search_key(MAX_WORD);
    write_entry_count(CNT_W'(0));
    search_key($urandom);
  endtask

  task automatic test_full_table();
    longint v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      v = longint'(MIN_WORD) + longint'(i) * 64'sd4194304;
      if (i == TABLE_DEPTH - 1) v = longint'(MAX_WORD);
      send_word(ACT_LOAD, i[IDX_W-1:0], v[VALUE_WIDTH-1:0]);
    end
    write_entry_count(CNT_W'(TABLE_DEPTH));
    search_key(MIN_WORD);
    search_key(MAX_WORD);
    search_key(shadow_table[511]);
    search_key(shadow_table[512]);
    search_key(MIN_WORD + 1);
    search_key(shadow_table[700] + 1);
    // A count beyond the table depth is clipped to the depth.
    write_entry_count({CNT_W{1'b1}});
    search_key(MAX_WORD);
    search_key(MIN_WORD);
  endtask

  task automatic test_small_counts();
    write_entry_count(CNT_W'(1));
    search_key(shadow_table[0]);
    search_key(MAX_WORD);
    write_entry_count(CNT_W'(2));
    search_key(shadow_table[1]);
  endtask

  task automatic test_duplicates();
    for (int i = 0; i < 4; i++) send_word(ACT_LOAD, i[IDX_W-1:0], 7);
    write_entry_count(CNT_W'(4));
    search_key(7);
    search_key(8);
  endtask

  task automatic test_unsorted();
    send_word(ACT_LOAD, '0, MAX_WORD);
    search_key(7);
    search_key(MAX_WORD);
  endtask

  task automatic test_random_phases();
    int sent;
    int phase;
    int n;
    int m;
    int searches;
    logic signed [VALUE_WIDTH-1:0] key;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 51;
        default: idle_pct = 12;
      endcase
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = 1;
        2:       n = TABLE_DEPTH;
        3:       n = $urandom_range(TABLE_DEPTH + 1, (1 << CNT_W) - 1);
        default: n = $urandom_range(2, 48);
      endcase
      write_entry_count(n[CNT_W-1:0]);
      m = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
      // The whole table has been written by now, so large counts reuse what is there.
      if (m <= 48) begin
        fill_ascending(m);
        sent += m;
      end
      searches = $urandom_range(4, 24);
      for (int s = 0; s < searches; s++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(ACT_LOAD, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom);
        end else begin
          if (m == 0) key = $urandom;
          else begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: key = shadow_table[IDX_W'($urandom_range(0, m - 1))];
              6:                key = shadow_table[IDX_W'($urandom_range(0, m - 1))] + 1;
              7:                key = shadow_table[IDX_W'($urandom_range(0, m - 1))] - 1;
              8:                key = $urandom;
              default:          key = $urandom_range(0, 1) ? MAX_WORD : MIN_WORD;
            endcase
          end
          search_key(key);
        end
        sent++;
      end
      phase++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_full_table();
    test_small_counts();
    test_duplicates();
    test_unsorted();
    test_random_phases();

    while (expected_lookups.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (!failed) begin
      $display("sorted_table_binary_search verification clean");
    end else begin
      $display("sorted_table_binary_search verification failed");
    end
    $finish;
  end

endmodule
